/* src/assert_macros.svh */
// Assertion helpers shared by the RTL. Both use the local clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define HPC_ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included
`define HPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/hpc_pkg.sv */
`default_nettype none

package hpc_pkg;

  localparam int MAX_V        = 9;   // rows on the input beat
  localparam int ROW_W        = 9;   // bits per adjacency row
  localparam int COUNT_W      = 19;  // holds 9!
  localparam int GRP          = 4;   // terms added per partial sum
  localparam int DEF_VERTICES = 9;

  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [MAX_V-1:0][ROW_W-1:0] row_arr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_ADD1,
    ST_ADD2,
    ST_FIN1,
    ST_FIN2
  } state_t;

  typedef struct packed {
    logic load;      // take rows, start at subset 1
    logic sum;       // register per-lane partial sums
    logic advance;   // write lane results, next subset
    logic fin_sum;   // partial sums of the full-set row
    logic load_out;  // total into output register
  } cmd_t;

  typedef struct packed {
    logic last;      // current subset is the full set
    logic out_free;  // output register can take a result
  } status_t;

endpackage

`default_nettype wire

/* src/hpc_ctrl.sv */
`default_nettype none

`include "assert_macros.svh"

module hpc_ctrl
  import hpc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        state_next = ST_ADD1;
      end
      ST_ADD1: begin
        cmd.sum    = 1'b1;
        state_next = ST_ADD2;
      end
      ST_ADD2: begin
        cmd.advance = 1'b1;
        state_next  = status.last ? ST_FIN1 : ST_RD;
      end
      ST_FIN1: begin
        cmd.fin_sum = 1'b1;
        state_next  = ST_FIN2;
      end
      ST_FIN2: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `HPC_ASSERT_ON(a_load_out_free, cmd.load_out |-> status.out_free, "result loaded over a pending beat")
  `HPC_ASSERT_ON(a_fin_after_last, state == ST_FIN1 |-> $past(state) == ST_ADD2 && $past(status.last), "final sum before full set")

endmodule

`default_nettype wire

/* src/hpc_dpath.sv */
`default_nettype none

`include "assert_macros.svh"

module hpc_dpath
  import hpc_pkg::*;
#(
  parameter int VERTICES = DEF_VERTICES
)
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire row_arr_t rows,
  input  wire cmd_t     cmd,
  output status_t       status,
  input  wire logic     out_ready,
  output logic          out_valid,
  output count_t        path_count
);

  localparam int SW    = VERTICES;
  localparam int DEPTH = 1 << VERTICES;
  localparam int NP    = (VERTICES + GRP - 1) / GRP;

  typedef logic [VERTICES-1:0][COUNT_W-1:0] lane_vec_t;
  typedef logic [NP-1:0][COUNT_W-1:0]       part_vec_t;

  row_arr_t  adj;
  logic [SW-1:0] subset;
  lane_vec_t rd_q [VERTICES];
  part_vec_t part [VERTICES];
  part_vec_t part_next [VERTICES];
  lane_vec_t lane_res;
  lane_vec_t fin_row;
  part_vec_t fin_part;
  part_vec_t fin_part_next;
  count_t    total_next;
  count_t    out_count;
  logic      out_valid_r;

  // One table copy per end vertex: copy v is read at subset minus v.
  for (genvar v = 0; v < VERTICES; v++) begin : g_bank
    localparam logic [SW-1:0] VBIT = {{(SW-1){1'b0}}, 1'b1} << v;
    lane_vec_t mem [DEPTH];

    always_ff @(posedge clk) begin
      if (cmd.advance) begin
        mem[subset] <= lane_res;
      end
      rd_q[v] <= mem[subset ^ VBIT];
    end
  end

  // Lane v: paths into v from every u of the predecessor subset.
  always_comb begin
    int u;
    for (int v = 0; v < VERTICES; v++) begin
      for (int g = 0; g < NP; g++) begin
        part_next[v][g] = '0;
        for (int k = 0; k < GRP; k++) begin
          u = g * GRP + k;
          if (u < VERTICES) begin
            if (subset[u] && (u != v) && adj[u][v]) begin
              part_next[v][g] = part_next[v][g] + rd_q[v][u];
            end
          end
        end
      end
    end
  end

  always_comb begin
    logic [SW-1:0] one_v;
    for (int v = 0; v < VERTICES; v++) begin
      one_v       = {{(SW-1){1'b0}}, 1'b1} << v;
      lane_res[v] = '0;
      if (subset[v]) begin
        if ((subset & ~one_v) == '0) begin
          lane_res[v] = count_t'(1);  // single-vertex path
        end else begin
          for (int g = 0; g < NP; g++) begin
            lane_res[v] = lane_res[v] + part[v][g];
          end
        end
      end
    end
  end

  always_comb begin
    int u;
    for (int g = 0; g < NP; g++) begin
      fin_part_next[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        u = g * GRP + k;
        if (u < VERTICES) begin
          fin_part_next[g] = fin_part_next[g] + fin_row[u];
        end
      end
    end
    total_next = '0;
    for (int g = 0; g < NP; g++) begin
      total_next = total_next + fin_part[g];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      adj    <= rows;
      subset <= SW'(1);
    end else if (cmd.advance) begin
      subset <= subset + SW'(1);
    end
    if (cmd.sum) begin
      part <= part_next;
    end
    if (cmd.advance && status.last) begin
      fin_row <= lane_res;
    end
    if (cmd.fin_sum) begin
      fin_part <= fin_part_next;
    end
    if (cmd.load_out) begin
      out_count <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.last     = &subset;
  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign path_count      = out_count;

  `HPC_ASSERT_ON(a_subset_step, cmd.advance && !status.last |=> subset == $past(subset) + SW'(1), "subset skipped")
  `HPC_ASSERT_ON(a_out_rise, $rose(out_valid_r) |-> $past(cmd.load_out), "result beat without load")
  `HPC_ASSERT_ALWAYS(a_rst_clear, rst |=> !out_valid_r, "result beat after reset")

endmodule

`default_nettype wire

/* src/hamiltonian_path_counter.sv */
// Each subset passes the table read port in turn through RD, ADD1 and ADD2.
// A new graph is taken only in idle, after the last result is registered;
//   a pending result does not block the next input beat, only the next
//   graph's finish.
// Reset (synchronous, active high) clears the controller and out_valid only;
//   the path table needs no clearing: each row used is written before it is read.
`default_nettype none

module hamiltonian_path_counter
  import hpc_pkg::*;
#(
  parameter int VERTICES = DEF_VERTICES
)
(
  input  wire logic clk,
  input  wire logic rst,

  input  wire logic in_valid,
  output logic      in_ready,
  input  wire row_t row_0,
  input  wire row_t row_1,
  input  wire row_t row_2,
  input  wire row_t row_3,
  input  wire row_t row_4,
  input  wire row_t row_5,
  input  wire row_t row_6,
  input  wire row_t row_7,
  input  wire row_t row_8,

  output logic      out_valid,
  input  wire logic out_ready,
  output count_t    path_count
);

  // Subset DP, pulled form: count[S][v] is the sum over u in S minus v,
  // with edge u->v, of count[S minus v][u]. Subsets go up from 1, so every
  // predecessor row is already in the table. The table keeps one copy per
  // end vertex so all lanes read their predecessor row in the same cycle.
  //
  // Per subset: RD issues the reads, ADD1 registers partial sums of four
  // terms per lane, ADD2 finishes the lanes and writes row S. After the full
  // set, FIN1/FIN2 add up its row into the output register.

  row_arr_t rows;
  cmd_t     cmd;
  status_t  status;

  assign rows = {row_8, row_7, row_6, row_5, row_4, row_3, row_2, row_1, row_0};

  hpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  hpc_dpath #(
    .VERTICES (VERTICES)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .rows       (rows),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .path_count (path_count)
  );

endmodule

`default_nettype wire
